// ===== design/ipsp_pkg.sv =====
// ----------------------------------------------------------------------------
// IPS patch parser package
// Shared types, codes and constants of the IPS patch stream parser.
// ----------------------------------------------------------------------------
package ipsp_pkg;

	localparam int unsigned SIZE_W          = 25;
	localparam int unsigned OFFSET_W        = 24;
	localparam int unsigned COUNT_W         = 16;
	localparam int unsigned CMD_QUEUE_DEPTH = 4;

	localparam logic [SIZE_W-1:0]   INIT_SIZE_RESET = 25'd8388608;
	localparam logic [OFFSET_W-1:0] EOF_MARK        = {8'h45, 8'h4F, 8'h46};

	// Result kinds as they appear on the result channel.
	typedef enum logic [1:0] {
		KIND_WRITE     = 2'd0,
		KIND_FILL      = 2'd1,
		KIND_DONE      = 2'd2,
		KIND_MALFORMED = 2'd3
	} kind_t;

	// One byte of the patch stream.
	typedef struct packed {
		logic [7:0] patch_byte;
		logic       final_byte;
	} item_t;

	// One result on the output channel.
	typedef struct packed {
		kind_t              kind;
		logic [SIZE_W-1:0]  address;
		logic [7:0]         value;
		logic [COUNT_W-1:0] run_length;
		logic [SIZE_W-1:0]  image_size;
		logic               last_of_run;
	} result_t;

	// Queue entry: everything one patch byte causes, at most one main
	// result followed by an optional malformed result.
	typedef struct packed {
		logic               has_main;
		kind_t              kind;
		logic [SIZE_W-1:0]  address;
		logic [7:0]         value;
		logic [COUNT_W-1:0] run_length;
		logic [SIZE_W-1:0]  image_size;
		logic               bad_end;
	} cmd_t;

	// Expected characters of the "PATCH" header.
	function automatic logic [7:0] magic_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = 8'h50;
			3'd1: ch = 8'h41;
			3'd2: ch = 8'h54;
			3'd3: ch = 8'h43;
			3'd4: ch = 8'h48;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== design/ips_patch_stream_parser.sv =====
// Path: a byte's results go through the command queue, then the output register.
// Throughput: one patch byte per cycle while the queue is not full; the emitter
// gives one result per cycle while the result channel does not stall, so a byte
// that causes a write or fill plus a malformed end keeps its entry until both go.
// Reset: arst_n clears the parser, queue and output register at once; the size
// register returns to 8388608 and no clearing pass is needed.
// ----------------------------------------------------------------------------
// IPS patch stream parser
// Turns an IPS patch, one byte at a time, into byte-write and fill-run
// commands for an image, and reports whether the patch ended properly.
// ----------------------------------------------------------------------------
//
// Structure: the parser front end decodes the "PATCH" header and the records
// and, for every byte that causes results, pushes one command into a short
// queue. The emitter back end pops commands and turns each into one or two
// results held in an output register. A full queue stalls the byte channel;
// a stalled result channel only fills the queue, so both sides run
// independently.
//
// Configuration: the single register, the initial image size, is always
// ready to take a request. It is loaded into the running image size at reset
// and after every final byte, so a new value takes effect with the next patch.
module ips_patch_stream_parser #(
	parameter int unsigned QUEUE_DEPTH = ipsp_pkg::CMD_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  ipsp_pkg::item_t             byte_item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output ipsp_pkg::result_t           result_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ipsp_pkg::SIZE_W-1:0] cfg_data
);
	import ipsp_pkg::*;

	logic [SIZE_W-1:0] init_size_q;
	logic              byte_accept;
	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	cmd_t              head;
	logic              head_valid;
	logic              queue_full;

	// The configuration register takes a request on every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_size_q <= INIT_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			init_size_q <= cfg_data;
		end
	end

	// A byte is taken whenever the queue has room for what it may cause.
	assign byte_stall  = queue_full;
	assign byte_accept = byte_valid && !byte_stall;

	ipsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (byte_accept),
		.item      (byte_item),
		.init_size (init_size_q),
		.push      (push),
		.cmd       (push_cmd)
	);

	ipsp_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (push_cmd),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.full      (queue_full)
	);

	ipsp_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

// ===== design/ipsp_parser.sv =====
// ----------------------------------------------------------------------------
// IPS patch parser front end
// Consumes one patch byte per cycle while accept is high, walks the record format
// and queues the results that the byte causes.
// ----------------------------------------------------------------------------
module ipsp_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  ipsp_pkg::item_t               item,
	input  logic [ipsp_pkg::SIZE_W-1:0]   init_size,
	output logic                          push,
	output ipsp_pkg::cmd_t                cmd
);
	import ipsp_pkg::*;

	typedef enum logic [6:0] {
		PH_MAGIC  = 7'b0000001,
		PH_OFFSET = 7'b0000010,
		PH_LENGTH = 7'b0000100,
		PH_DATA   = 7'b0001000,
		PH_RCOUNT = 7'b0010000,
		PH_RFILL  = 7'b0100000,
		PH_IDLE   = 7'b1000000
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [2:0]           idx_q, idx_d;
	logic [OFFSET_W-1:0]  offset_q, offset_d;
	logic [COUNT_W-1:0]   length_q, length_d;
	logic [COUNT_W-1:0]   left_q, left_d;
	logic [SIZE_W-1:0]    waddr_q, waddr_d;
	logic [SIZE_W-1:0]    size_q, size_d;

	logic [7:0]           pbyte;
	logic [OFFSET_W-1:0]  new_offset;
	logic [COUNT_W-1:0]   new_length;
	logic [COUNT_W-1:0]   new_count;
	logic [SIZE_W-1:0]    length_end;
	logic [SIZE_W-1:0]    fill_end;
	logic                 has_main;
	kind_t                main_kind;
	logic [SIZE_W-1:0]    main_addr;
	logic [7:0]           main_value;
	logic [COUNT_W-1:0]   main_run;
	logic                 bad_end;

	assign pbyte      = item.patch_byte;
	assign new_offset = {offset_q[OFFSET_W-9:0], pbyte};
	assign new_length = {length_q[COUNT_W-9:0], pbyte};
	assign new_count  = {left_q[COUNT_W-9:0], pbyte};
	assign length_end = {1'b0, offset_q} + {{(SIZE_W-COUNT_W){1'b0}}, new_length};
	assign fill_end   = {1'b0, offset_q} + {{(SIZE_W-COUNT_W){1'b0}}, left_q};

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		offset_d   = offset_q;
		length_d   = length_q;
		left_d     = left_q;
		waddr_d    = waddr_q;
		size_d     = size_q;
		has_main   = 1'b0;
		main_kind  = KIND_WRITE;
		main_addr  = '0;
		main_value = '0;
		main_run   = '0;
		case (phase_q)
			PH_MAGIC: begin
				if (idx_q > 3'd4 || pbyte != magic_char(idx_q)) begin
					has_main  = 1'b1;
					main_kind = KIND_MALFORMED;
					phase_d   = PH_IDLE;
				end else if (idx_q == 3'd4) begin
					idx_d    = '0;
					offset_d = '0;
					phase_d  = PH_OFFSET;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_OFFSET: begin
				offset_d = new_offset;
				if (idx_q >= 3'd2) begin
					idx_d = '0;
					if (new_offset == EOF_MARK) begin
						has_main  = 1'b1;
						main_kind = KIND_DONE;
						phase_d   = PH_IDLE;
					end else begin
						length_d = '0;
						phase_d  = PH_LENGTH;
					end
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_LENGTH: begin
				length_d = new_length;
				if (idx_q >= 3'd1) begin
					idx_d = '0;
					if (new_length == '0) begin
						left_d  = '0;
						phase_d = PH_RCOUNT;
					end else begin
						if (length_end > size_q) begin
							size_d = length_end;
						end
						waddr_d = {1'b0, offset_q};
						left_d  = new_length;
						phase_d = PH_DATA;
					end
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_DATA: begin
				has_main   = 1'b1;
				main_kind  = KIND_WRITE;
				main_addr  = waddr_q;
				main_value = pbyte;
				waddr_d    = waddr_q + 1'b1;
				left_d     = left_q - 1'b1;
				if (left_q == COUNT_W'(1)) begin
					offset_d = '0;
					phase_d  = PH_OFFSET;
				end
			end
			PH_RCOUNT: begin
				left_d = new_count;
				if (idx_q >= 3'd1) begin
					idx_d   = '0;
					phase_d = PH_RFILL;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_RFILL: begin
				if (fill_end > size_q) begin
					size_d = fill_end;
				end
				has_main   = 1'b1;
				main_kind  = KIND_FILL;
				main_addr  = {1'b0, offset_q};
				main_value = pbyte;
				main_run   = left_q;
				offset_d   = '0;
				phase_d    = PH_OFFSET;
			end
			default: begin
			end
		endcase
		bad_end = item.final_byte && (phase_d != PH_IDLE);
	end

	assign push = accept && (has_main || bad_end);

	always_comb begin
		cmd.has_main   = has_main;
		cmd.kind       = main_kind;
		cmd.address    = main_addr;
		cmd.value      = main_value;
		cmd.run_length = main_run;
		cmd.image_size = size_d;
		cmd.bad_end    = bad_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			idx_q    <= '0;
			offset_q <= '0;
			length_q <= '0;
			left_q   <= '0;
			waddr_q  <= '0;
			size_q   <= INIT_SIZE_RESET;
		end else if (accept) begin
			if (item.final_byte) begin
				phase_q  <= PH_MAGIC;
				idx_q    <= '0;
				offset_q <= '0;
				length_q <= '0;
				left_q   <= '0;
				waddr_q  <= '0;
				size_q   <= init_size;
			end else begin
				phase_q  <= phase_d;
				idx_q    <= idx_d;
				offset_q <= offset_d;
				length_q <= length_d;
				left_q   <= left_d;
				waddr_q  <= waddr_d;
				size_q   <= size_d;
			end
		end
	end

	// The field byte counter never runs past the last header character.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd4)
		else $error("field byte index out of range");

endmodule

// ===== design/ipsp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// IPS patch parser command queue
// Small first-in first-out queue between the parser and the result emitter.
// ----------------------------------------------------------------------------
module ipsp_cmd_fifo #(
	parameter int unsigned DEPTH = ipsp_pkg::CMD_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ipsp_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output ipsp_pkg::cmd_t head,
	output logic           not_empty,
	output logic           full
);
	import ipsp_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("command popped from an empty queue");

endmodule

// ===== design/ipsp_emitter.sv =====
// ----------------------------------------------------------------------------
// IPS patch parser result emitter
// Expands each queued command into one or two results and holds them in an
// output register until the consumer takes them.
// ----------------------------------------------------------------------------
module ipsp_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  ipsp_pkg::cmd_t    head,
	input  logic              head_valid,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output ipsp_pkg::result_t result_item
);
	import ipsp_pkg::*;

	logic    valid_q;
	result_t data_q;
	logic    sub_q;
	logic    load;
	logic    first_main;
	result_t next_res;

	assign load       = head_valid && (!valid_q || !result_stall);
	assign first_main = head.has_main && !sub_q;
	assign pop        = load && !(first_main && head.bad_end);

	always_comb begin
		next_res.kind        = first_main ? head.kind : KIND_MALFORMED;
		next_res.address     = first_main ? head.address : '0;
		next_res.value       = first_main ? head.value : '0;
		next_res.run_length  = first_main ? head.run_length : '0;
		next_res.image_size  = head.image_size;
		next_res.last_of_run = first_main ? !head.bad_end : 1'b1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q   <= first_main && head.bad_end;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign result_item  = data_q;

	// A pending malformed result always belongs to the entry still queued.
	a_sub_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> head_valid)
		else $error("second result pending without a queued command");

endmodule
